// ===== src/bept_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bept_pkg: shared types and constants of the block execution profile tally
// Command codes, counter indexes, micro-op class decode and the control and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bept_pkg;

    localparam int BLOCKS_DEF = 256;
    localparam int SLOTS_DEF  = 32;

    localparam int NCNT   = 10;
    localparam int CNT_W  = 32;
    localparam int TOT_W  = 64;
    localparam int CIDX_W = 4;
    localparam int BINS   = 256;

    localparam logic [CIDX_W-1:0] C_UOPS   = 4'd0;
    localparam logic [CIDX_W-1:0] C_INS    = 4'd1;
    localparam logic [CIDX_W-1:0] C_ALU    = 4'd2;
    localparam logic [CIDX_W-1:0] C_LOAD   = 4'd3;
    localparam logic [CIDX_W-1:0] C_STORE  = 4'd4;
    localparam logic [CIDX_W-1:0] C_BRANCH = 4'd5;
    localparam logic [CIDX_W-1:0] C_FPU    = 4'd6;
    localparam logic [CIDX_W-1:0] C_SHIFT  = 4'd7;
    localparam logic [CIDX_W-1:0] C_MMX    = 4'd8;
    localparam logic [CIDX_W-1:0] C_MISC   = 4'd9;

    localparam logic [CNT_W-1:0] CNT_MAX = 32'hffff_ffff;

    typedef enum logic [2:0] {
        CMD_CLEAR_ALL    = 3'd0,
        CMD_BLOCK_START  = 3'd1,
        CMD_OPCODE_SEEN  = 3'd2,
        CMD_CENSUS_BEGIN = 3'd3,
        CMD_CENSUS_UOP   = 3'd4,
        CMD_EXECUTED     = 3'd5,
        CMD_READ_TOTAL   = 3'd6,
        CMD_READ_BIN     = 3'd7
    } cmd_t;

    typedef struct packed {
        logic latch;
        logic dispatch;
        logic clr_step;
        logic rec_wr;
        logic srch_step;
        logic tot_add;
        logic hist_step;
        logic out_fire;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic ok;
        logic en;
        logic clr_last;
        logic srch_done;
        logic hist_done;
    } dp_stat_t;

    function automatic logic [CIDX_W-1:0] uop_class(input logic [7:0] b);
        logic [CIDX_W-1:0] c;
        c = C_MISC;
        if ((b >= 8'h28 && b <= 8'h2a) || b == 8'h40 || b == 8'h41 || b == 8'h47
            || b == 8'h49)
            c = C_LOAD;
        else if ((b >= 8'h42 && b <= 8'h46) || b == 8'h4a || b == 8'h4b)
            c = C_STORE;
        else if (b == 8'h15 || b == 8'h17 || b == 8'h48 || b == 8'h4c || b == 8'h4d
                 || (b >= 8'h60 && b <= 8'h71))
            c = C_BRANCH;
        else if ((b >= 8'h25 && b <= 8'h27) || (b >= 8'h80 && b <= 8'h8a))
            c = C_FPU;
        else if (b >= 8'h90 && b <= 8'hce)
            c = C_MMX;
        else if (b >= 8'h50 && b <= 8'h59)
            c = C_SHIFT;
        else if ((b >= 8'h20 && b <= 8'h24) || (b >= 8'h30 && b <= 8'h3b))
            c = C_ALU;
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/bept_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bept_ctrl: command sequencer
// One-hot state machine that steps the datapath through each command.
// ----------------------------------------------------------------------------
module bept_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  bept_pkg::dp_stat_t     stat,
    output bept_pkg::ctl_cmd_t     ctl
);
    import bept_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DISPATCH = 8'b0000_0010,
        ST_CLEAR    = 8'b0000_0100,
        ST_REC_WR   = 8'b0000_1000,
        ST_SRCH     = 8'b0001_0000,
        ST_TOTAL    = 8'b0010_0000,
        ST_HIST     = 8'b0100_0000,
        ST_READ_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                ctl.dispatch = 1'b1;
                unique case (stat.cmd)
                    CMD_CLEAR_ALL:
                        state_next = ST_CLEAR;
                    CMD_BLOCK_START, CMD_CENSUS_BEGIN, CMD_CENSUS_UOP:
                        state_next = stat.ok ? ST_REC_WR : ST_IDLE;
                    CMD_OPCODE_SEEN:
                        state_next = (stat.ok && stat.en) ? ST_SRCH : ST_IDLE;
                    CMD_EXECUTED:
                        state_next = (stat.ok && stat.en) ? ST_TOTAL : ST_IDLE;
                    CMD_READ_TOTAL, CMD_READ_BIN:
                        state_next = ST_READ_OUT;
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_REC_WR:
            begin
                ctl.rec_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SRCH:
            begin
                ctl.srch_step = 1'b1;
                if (stat.srch_done)
                    state_next = ST_IDLE;
            end
            ST_TOTAL:
            begin
                ctl.tot_add = 1'b1;
                state_next  = ST_HIST;
            end
            ST_HIST:
            begin
                if (stat.hist_done)
                    state_next = ST_IDLE;
                else
                    ctl.hist_step = 1'b1;
            end
            ST_READ_OUT:
            begin
                ctl.out_fire = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // reset runs the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

    a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.latch |=> (state_reg == ST_DISPATCH))
        else $error("latch did not lead to dispatch");
    a_tot_then_hist: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.tot_add |=> (state_reg == ST_HIST))
        else $error("totals not followed by histogram pass");
    a_fire_one: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_fire |=> !ctl.out_fire)
        else $error("result fired twice");

endmodule
`default_nettype wire

// ===== src/bept_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bept_dp: tally datapath
// Block record, slot and histogram memories, running totals and result port.
// ----------------------------------------------------------------------------
module bept_dp #(
    parameter int BLOCKS = bept_pkg::BLOCKS_DEF,
    parameter int SLOTS  = bept_pkg::SLOTS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  bept_pkg::ctl_cmd_t ctl,
    output bept_pkg::dp_stat_t stat,
    input  wire logic [2:0]    command,
    input  wire logic [7:0]    block_number,
    input  wire logic [7:0]    opcode_byte,
    input  wire logic [7:0]    uop_class_byte,
    input  wire logic [31:0]   instruction_count,
    input  wire logic [7:0]    read_index,
    input  wire logic          profiling_enabled_we,
    input  wire logic          profiling_enabled,
    output logic               read_valid,
    output logic [63:0]        read_value
);
    import bept_pkg::*;

    localparam int BW    = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int UW    = $clog2(SLOTS + 1);
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CLR_N = (BLOCKS > BINS) ? BLOCKS : BINS;
    localparam int CW    = $clog2(CLR_N);
    localparam int CB    = NCNT * CNT_W;
    localparam int RW    = CB + UW;
    localparam int SD    = BLOCKS * (1 << SW);

    // latched item
    cmd_t        cmd_reg;
    logic [7:0]  blk_reg, opc_reg, ucls_reg, ridx_reg;
    logic [31:0] icnt_reg;
    logic        en_reg;

    // memories
    logic [RW-1:0]    rec_mem [BLOCKS];
    logic [39:0]      slot_mem [SD];
    logic [TOT_W-1:0] hist_mem [BINS];
    logic [RW-1:0]    rec_q;
    logic [39:0]      slot_q;
    logic [TOT_W-1:0] hist_q;

    // sequencing registers
    logic [CW-1:0] clr_reg, clr_next;
    logic [UW-1:0] idx_reg, idx_next;
    logic [SW-1:0] pidx_reg, pidx_next;
    logic          pend_reg, pend_next;
    logic          v1_reg, v1_next, v2_reg, v2_next;
    logic [31:0]   cnt2_reg;
    logic [7:0]    op2_reg;
    logic [NCNT-1:0][TOT_W-1:0] tot_reg;
    logic          rv_reg;
    logic [63:0]   rval_reg;

    logic [BW+7:0]   blk_w;
    logic [BW-1:0]   blk_a;
    logic [NCNT-1:0][CNT_W-1:0] cnt_q, cnt_w;
    logic [UW-1:0]   used_q;
    logic [CIDX_W-1:0] cls;
    logic            ok, hit, more;

    logic            rec_we;
    logic [BW-1:0]   rec_wa;
    logic [RW-1:0]   rec_wd;
    logic            slot_re, slot_we;
    logic [SW-1:0]   slot_ri, slot_wi;
    logic [39:0]     slot_wd;
    logic            hist_re, hist_we;
    logic [7:0]      hist_ra, hist_wa;
    logic [TOT_W-1:0] hist_wd;

    assign blk_w  = {{BW{1'b0}}, blk_reg};
    assign blk_a  = blk_w[BW-1:0];
    assign ok     = ({24'd0, blk_reg} < 32'(BLOCKS));
    assign cnt_q  = rec_q[CB-1:0];
    assign used_q = rec_q[RW-1 -: UW];
    assign cls    = uop_class(ucls_reg);
    assign hit    = pend_reg && (slot_q[39:32] == opc_reg);
    assign more   = (idx_reg < used_q);

    always_comb
    begin
        clr_next  = clr_reg;
        idx_next  = idx_reg;
        pidx_next = pidx_reg;
        pend_next = pend_reg;
        v1_next   = v1_reg;
        v2_next   = v2_reg;
        rec_we    = 1'b0;
        rec_wa    = blk_a;
        rec_wd    = rec_q;
        slot_re   = 1'b0;
        slot_ri   = idx_reg[SW-1:0];
        slot_we   = 1'b0;
        slot_wi   = pidx_reg;
        slot_wd   = slot_q;
        hist_re   = 1'b0;
        hist_ra   = ridx_reg;
        hist_we   = 1'b0;
        hist_wa   = op2_reg;
        hist_wd   = hist_q + {32'd0, cnt2_reg};
        cnt_w     = cnt_q;

        if (ctl.latch)
        begin
            clr_next  = '0;
            idx_next  = '0;
            pend_next = 1'b0;
            v1_next   = 1'b0;
            v2_next   = 1'b0;
        end

        if (ctl.dispatch)
            hist_re = 1'b1;

        // clearing pass: one record row and one bin per cycle
        if (ctl.clr_step)
        begin
            clr_next = clr_reg + 1'b1;
            rec_wa   = clr_reg[BW-1:0];
            rec_wd   = '0;
            rec_we   = ({{(32-CW){1'b0}}, clr_reg} < 32'(BLOCKS));
            hist_wa  = clr_reg[7:0];
            hist_wd  = '0;
            hist_we  = ({{(32-CW){1'b0}}, clr_reg} < 32'(BINS));
        end

        if (ctl.rec_wr)
        begin
            rec_we = 1'b1;
            unique case (cmd_reg)
                CMD_BLOCK_START:
                    rec_wd = '0;
                CMD_CENSUS_BEGIN:
                begin
                    cnt_w        = '0;
                    cnt_w[C_INS] = icnt_reg;
                    rec_wd       = {used_q, cnt_w};
                end
                CMD_CENSUS_UOP:
                begin
                    cnt_w[cls]    = cnt_q[cls] + 32'd1;
                    cnt_w[C_UOPS] = cnt_q[C_UOPS] + 32'd1;
                    rec_wd        = {used_q, cnt_w};
                end
                default:
                    rec_wd = rec_q;
            endcase
        end

        // opcode search: compare the slot read last cycle, issue the next
        if (ctl.srch_step)
        begin
            if (hit)
            begin
                slot_we = 1'b1;
                slot_wi = pidx_reg;
                slot_wd = {opc_reg, (slot_q[31:0] < CNT_MAX) ? slot_q[31:0] + 32'd1
                                                             : slot_q[31:0]};
            end
            else if (more)
            begin
                slot_re   = 1'b1;
                pidx_next = idx_reg[SW-1:0];
                idx_next  = idx_reg + 1'b1;
                pend_next = 1'b1;
            end
            else if (used_q < UW'(SLOTS))
            begin
                slot_we = 1'b1;
                slot_wi = used_q[SW-1:0];
                slot_wd = {opc_reg, 32'd1};
                rec_we  = 1'b1;
                rec_wd  = {used_q + 1'b1, cnt_q};
            end
        end

        // histogram pass: slot read, bin read, bin write
        if (ctl.hist_step)
        begin
            slot_re  = more;
            idx_next = more ? idx_reg + 1'b1 : idx_reg;
            v1_next  = more;
            hist_re  = v1_reg;
            hist_ra  = slot_q[39:32];
            v2_next  = v1_reg;
            hist_we  = v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
            rec_mem[rec_wa] <= rec_wd;
        if (ctl.dispatch)
            rec_q <= rec_mem[blk_a];
        if (slot_we)
            slot_mem[{blk_a, slot_wi}] <= slot_wd;
        if (slot_re)
            slot_q <= slot_mem[{blk_a, slot_ri}];
        if (hist_we)
            hist_mem[hist_wa] <= hist_wd;
        if (hist_re)
            hist_q <= hist_mem[hist_ra];
    end

    // latched fields and pipeline payload
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg  <= cmd_t'(command);
            blk_reg  <= block_number;
            opc_reg  <= opcode_byte;
            ucls_reg <= uop_class_byte;
            icnt_reg <= instruction_count;
            ridx_reg <= read_index;
        end
        if (ctl.hist_step)
        begin
            cnt2_reg <= slot_q[31:0];
            op2_reg  <= slot_q[39:32];
        end
        if (ctl.out_fire)
        begin
            if (cmd_reg == CMD_READ_TOTAL)
                rval_reg <= (ridx_reg < 8'(NCNT)) ? tot_reg[ridx_reg[CIDX_W-1:0]] : '0;
            else
                rval_reg <= hist_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= 1'b0;
            clr_reg  <= '0;
            idx_reg  <= '0;
            pidx_reg <= '0;
            pend_reg <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            rv_reg   <= 1'b0;
            tot_reg  <= '0;
        end
        else
        begin
            if (profiling_enabled_we)
                en_reg <= profiling_enabled;
            clr_reg  <= clr_next;
            idx_reg  <= idx_next;
            pidx_reg <= pidx_next;
            pend_reg <= pend_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            rv_reg   <= ctl.out_fire;
            if (ctl.clr_step)
                tot_reg <= '0;
            else if (ctl.tot_add)
            begin
                for (int i = 0; i < NCNT; i++)
                    tot_reg[i] <= tot_reg[i] + {32'd0, cnt_q[i]};
            end
        end
    end

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.ok        = ok;
        stat.en        = en_reg;
        stat.clr_last  = ({{(32-CW){1'b0}}, clr_reg} == 32'(CLR_N - 1));
        stat.srch_done = hit || !more;
        stat.hist_done = !more && !v1_reg && !v2_reg;
    end

    assign read_valid = rv_reg;
    assign read_value = rval_reg;

    a_slot_idx: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |-> ({{(32-SW){1'b0}}, slot_wi} < 32'(SLOTS)))
        else $error("slot write beyond table");
    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.srch_step |-> (used_q <= UW'(SLOTS)))
        else $error("slot count above capacity");
    a_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr_step |-> !(ctl.hist_step || ctl.srch_step))
        else $error("clearing overlaps an update");

endmodule
`default_nettype wire

// ===== src/block_execution_profile_tally.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_execution_profile_tally: per-block execution profile counters
// Per-block census and opcode counts, folded into running totals and an
// opcode histogram on each executed event.
// ----------------------------------------------------------------------------
// Issue a beat with start while busy is low; busy then stays high until the
// command is done. Read results appear on read_value for exactly one cycle
// with read_valid and cannot be held off, so take them when they come.
// Block start, census begin and census uop each write one record row; read
// total and read bin raise read_valid in the cycle busy falls; opcode seen
// compares one slot per cycle through the slot memory read port (used <=
// SLOTS) until a hit or the last used slot; executed adds the record into
// the totals, then runs slot read, bin read and bin write pipelined through
// the histogram memory; disabled or out-of-range events end after dispatch.
// Clear all, and the pass after reset, sweep one record row and one bin per
// cycle over every record row and all 256 bins, during which busy is high.
// Write profiling_enabled only while busy is low and no beat is being
// issued.
// ----------------------------------------------------------------------------
module block_execution_profile_tally #(
    parameter int BLOCKS = bept_pkg::BLOCKS_DEF,
    parameter int SLOTS  = bept_pkg::SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [7:0]  block_number,
    input  wire logic [7:0]  opcode_byte,
    input  wire logic [7:0]  uop_class_byte,
    input  wire logic [31:0] instruction_count,
    input  wire logic [7:0]  read_index,
    input  wire logic        profiling_enabled_we,
    input  wire logic        profiling_enabled,
    output logic             read_valid,
    output logic [63:0]      read_value
);
    import bept_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    // sequence each command
    bept_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    // hold counters, memories and the result register
    bept_dp #(
        .BLOCKS (BLOCKS),
        .SLOTS  (SLOTS)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .ctl                  (ctl),
        .stat                 (stat),
        .command              (command),
        .block_number         (block_number),
        .opcode_byte          (opcode_byte),
        .uop_class_byte       (uop_class_byte),
        .instruction_count    (instruction_count),
        .read_index           (read_index),
        .profiling_enabled_we (profiling_enabled_we),
        .profiling_enabled    (profiling_enabled),
        .read_valid           (read_valid),
        .read_value           (read_value)
    );

endmodule
`default_nettype wire
